// ===== rtl/acf_pkg.sv =====
// Shared types, sizes and the division step for the ARGB frame crossfade.
package acf_pkg;

	localparam int CHAN_W  = 8;   // one color channel
	localparam int NUM_CH  = 3;   // R, G, B
	localparam int DUR_W   = 16;  // tick counts
	localparam int PIX_W   = 32;
	localparam int NUM_W   = CHAN_W + DUR_W;  // a*(T-t) + b*t <= 255*T
	localparam int IN_W    = 2 * PIX_W + 2 * DUR_W;

	localparam int DIV_STAGES      = 4;
	localparam int STEPS_PER_STAGE = CHAN_W / DIV_STAGES;

	// Channel slots; R in the highest
	localparam int CH_B = 0;
	localparam int CH_G = 1;
	localparam int CH_R = 2;

	typedef logic [NUM_CH-1:0][NUM_W-1:0]  num_vec_t;
	typedef logic [NUM_CH-1:0][CHAN_W-1:0] chan_vec_t;

	// Item handed from the multiply front end to the divider
	typedef struct packed {
		logic [CHAN_W-1:0] alpha;
		logic [DUR_W-1:0]  dur;
		num_vec_t          num;
	} acf_mix_t;

	// One restoring step: {quotient bit, new remainder}
	function automatic logic [NUM_W:0] div_step(input logic [NUM_W-1:0] rem,
			input logic [DUR_W-1:0] dur, input int unsigned sh);
		logic [NUM_W-1:0] d;
		d = NUM_W'(dur) << sh;
		if (rem >= d) begin
			return {1'b1, NUM_W'(rem - d)};
		end
		return {1'b0, rem};
	endfunction

endpackage

// ===== rtl/acf_front.sv =====
// Front end: duration and tick clamp, then the two weighted products per channel.
module acf_front import acf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [PIX_W-1:0]    pixel_from,
	input  logic [PIX_W-1:0]    pixel_to,
	input  logic [DUR_W-1:0]    ticks_elapsed,
	input  logic [DUR_W-1:0]    frame_duration,
	output logic                out_valid,
	input  logic                out_ready,
	output acf_mix_t            out_item
);

	logic              valid_s1, valid_s2;
	logic              rdy_s1, rdy_s2;
	logic [CHAN_W-1:0] alpha_s1;
	chan_vec_t         a_s1, b_s1;
	logic [DUR_W-1:0]  dur_s1, t_s1, w_s1;
	acf_mix_t          item_s2;

	logic [DUR_W-1:0]  dur_eff, t_clamp;
	num_vec_t          num_c;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		dur_eff = (frame_duration == '0) ? DUR_W'(1) : frame_duration;
		t_clamp = (ticks_elapsed > dur_eff) ? dur_eff : ticks_elapsed;
	end

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			num_c[c] = NUM_W'(NUM_W'(a_s1[c]) * NUM_W'(w_s1) + NUM_W'(b_s1[c]) * NUM_W'(t_s1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= in_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			alpha_s1 <= pixel_from[PIX_W-1 -: CHAN_W];
			for (int c = 0; c < NUM_CH; c++) begin
				a_s1[c] <= pixel_from[c*CHAN_W +: CHAN_W];
				b_s1[c] <= pixel_to[c*CHAN_W +: CHAN_W];
			end
			dur_s1 <= dur_eff;
			t_s1   <= t_clamp;
			w_s1   <= dur_eff - t_clamp;
		end
		if (rdy_s2 && valid_s1) begin
			item_s2.alpha <= alpha_s1;
			item_s2.dur   <= dur_s1;
			item_s2.num   <= num_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

endmodule

// ===== rtl/acf_divider.sv =====
// Pipelined restoring divider: num / dur for three channels, two quotient bits a stage.
module acf_divider import acf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  acf_mix_t           in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   blended_pixel
);

	// Stage k registers, k = 0 .. DIV_STAGES-1
	logic              valid_s [DIV_STAGES];
	logic [CHAN_W-1:0] alpha_s [DIV_STAGES];
	logic [DUR_W-1:0]  dur_s   [DIV_STAGES];
	num_vec_t          rem_s   [DIV_STAGES];
	chan_vec_t         quo_s   [DIV_STAGES];
	logic              rdy     [DIV_STAGES+1];

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic              v_in;
		logic [CHAN_W-1:0] alpha_in;
		logic [DUR_W-1:0]  dur_in;
		num_vec_t          rem_in, rem_nx;
		chan_vec_t         quo_in, quo_nx;

		if (k == 0) begin : g_first
			assign v_in     = in_valid;
			assign alpha_in = in_item.alpha;
			assign dur_in   = in_item.dur;
			assign rem_in   = in_item.num;
			assign quo_in   = '0;
		end else begin : g_next
			assign v_in     = valid_s[k-1];
			assign alpha_in = alpha_s[k-1];
			assign dur_in   = dur_s[k-1];
			assign rem_in   = rem_s[k-1];
			assign quo_in   = quo_s[k-1];
		end

		assign rdy[k] = !valid_s[k] || rdy[k+1];

		always_comb begin
			logic [NUM_W:0] st;
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int c = 0; c < NUM_CH; c++) begin
				for (int j = 0; j < STEPS_PER_STAGE; j++) begin
					st = div_step(rem_nx[c], dur_in,
						CHAN_W - 1 - k * STEPS_PER_STAGE - j);
					rem_nx[c] = st[NUM_W-1:0];
					quo_nx[c] = {quo_nx[c][CHAN_W-2:0], st[NUM_W]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_in) begin
				alpha_s[k] <= alpha_in;
				dur_s[k]   <= dur_in;
				rem_s[k]   <= rem_nx;
				quo_s[k]   <= quo_nx;
			end
		end
	end

	assign out_valid     = valid_s[DIV_STAGES-1];
	assign blended_pixel = {alpha_s[DIV_STAGES-1], quo_s[DIV_STAGES-1][CH_R],
		quo_s[DIV_STAGES-1][CH_G], quo_s[DIV_STAGES-1][CH_B]};

endmodule

// ===== rtl/argb_frame_crossfade.sv =====
// ARGB frame crossfade: each item mixes a pixel of the current frame with the
// pixel of the next frame as floor((a*(T-t) + b*t) / T) per color channel, with
// alpha passed from the current pixel, t clamped to T and a zero T taken as one.
// The block is a six-stage pipeline (clamp, multiply, then four stages of a
// restoring divider giving two quotient bits each): it takes one item per cycle
// while the output side does not stall. A stall backs up stage by stage without
// losing items.
module argb_frame_crossfade import acf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// pixel_from [31:0], pixel_to [63:32], ticks_elapsed [79:64], frame_duration [95:80]
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// blended_pixel [31:0]
	output logic [PIX_W-1:0]   m_tdata
);

	logic     mix_valid, mix_ready;
	acf_mix_t mix_item;

	acf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.pixel_from     (s_tdata[PIX_W-1:0]),
		.pixel_to       (s_tdata[2*PIX_W-1:PIX_W]),
		.ticks_elapsed  (s_tdata[2*PIX_W+DUR_W-1:2*PIX_W]),
		.frame_duration (s_tdata[IN_W-1:2*PIX_W+DUR_W]),
		.out_valid      (mix_valid),
		.out_ready      (mix_ready),
		.out_item       (mix_item)
	);

	acf_divider u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (mix_valid),
		.in_ready      (mix_ready),
		.in_item       (mix_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.blended_pixel (m_tdata)
	);

	// a free output side means every stage can move
	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output side is free");

	// input only stalls when the whole pipe is full and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && mix_valid))
		else $error("input stalled with a bubble in the pipeline");

	a_mix_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!mix_ready) |-> (m_tvalid && !m_tready))
		else $error("divider stalled without output backpressure");

endmodule
